// ----- rtl/core/fir_same_edge_passthrough_assert.svh -----
// Assertion macros used by the filter's RTL file.
`ifndef FIR_SAME_EDGE_PASSTHROUGH_ASSERT_SVH
`define FIR_SAME_EDGE_PASSTHROUGH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fsep_pkg.sv -----
`default_nettype none

package fsep_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int FRAC_W       = 15;
	localparam int POS_W        = 3;
	localparam int NUM_TAP_REGS = 7;
	localparam int CFG_IDX_W    = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [POS_W-1:0]           pos_t;

	localparam pos_t    POS_MAX    = 3'd7;
	localparam sample_t TAP_RESET  = 16'sd4681;
	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;
	localparam int      SAT_HI     = 32767;
	localparam int      SAT_LO     = -32768;
	localparam int      ROUND_BIAS = 1 << (FRAC_W - 1);

endpackage

`default_nettype wire

// ----- rtl/core/fsep_in_if.sv -----
`default_nettype none

interface fsep_in_if import fsep_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    final_sample;

	modport source (output valid, output sample, output final_sample, input ready);
	modport sink (input valid, input sample, input final_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fsep_out_if.sv -----
`default_nettype none

interface fsep_out_if import fsep_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t value;
	logic    passed_through;
	logic    run_end;

	modport source (output valid, output value, output passed_through, output run_end,
		input ready);
	modport sink (input valid, input value, input passed_through, input run_end,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fir_same_edge_passthrough.sv -----
`default_nettype none

// Centered odd-length FIR over a record of signed 16-bit samples, with the first
// (TAPS-1)/2+1 and the last (TAPS-1)/2 outputs passed through unfiltered. One sample
// is taken per clock while no burst is pending; a non-final sample gives at most
// one word, while a final sample gives up to (TAPS-1)/2+1 words, one per cycle while
// results.ready is high, and no sample is taken until the last of them is taken. The
// rate is set by the output stage, which holds one sample's burst of words; the
// products are formed in parallel, one multiplier per tap. A word passes the window,
// product, sum and output registers in turn. Taps are Q1.15; the user must write
// them through cfg_we, cfg_index and cfg_data while idle; the block does not check.
module fir_same_edge_passthrough import fsep_pkg::*; #(
	parameter int TAPS = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	fsep_in_if.sink                   samples,
	fsep_out_if.source                results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SAMPLE_W-1:0]  cfg_data
);

	localparam int HALF = (TAPS - 1) / 2;
	localparam int AW   = (HALF > 1) ? $clog2(HALF + 1) : 1;
	localparam int TIW  = $clog2(TAPS);
	localparam int SW   = 2 * SAMPLE_W + $clog2(TAPS);
	localparam int QW   = SW - FRAC_W;

	sample_t taps_q [TAPS];
	sample_t hist_q [TAPS-1];
	pos_t    pos_q;

	sample_t         win_n [TAPS];
	logic            acc;
	logic            adv;
	logic            emit_done;

	logic            vld_s1;
	sample_t         win_s1 [TAPS];
	logic            emit_s1;
	logic            fin_s1;
	logic            usef_s1;
	logic [AW-1:0]   age_s1;

	logic                       vld_s2;
	logic signed [2*SAMPLE_W-1:0] prod_s2 [TAPS];
	sample_t                    win_s2 [HALF+1];
	logic                       fin_s2;
	logic                       usef_s2;
	logic [AW-1:0]              age_s2;

	logic            vld_s3;
	sample_t         filt_s3;
	sample_t         win_s3 [HALF+1];
	logic            fin_s3;
	logic            usef_s3;
	logic [AW-1:0]   age_s3;

	logic            busy_q;
	sample_t         filt_q;
	sample_t         win_q [HALF+1];
	logic            fin_q;
	logic            usef_q;
	logic [AW-1:0]   age_q;

	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] rnd_c;
	logic signed [QW-1:0] quo_c;
	sample_t              sat_c;
	logic                 pass_c;

	assign emit_done = busy_q && results.ready && (!fin_q || age_q == '0);
	assign adv       = !busy_q || emit_done;
	assign acc       = samples.valid && adv;
	assign samples.ready = adv;

	always_comb begin
		win_n[0] = samples.sample;
		for (int j = 1; j < TAPS; j++) begin
			win_n[j] = hist_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TAPS; j++) begin
				taps_q[j] <= TAP_RESET;
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(TAPS)) begin
			taps_q[cfg_index[TIW-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TAPS - 1; j++) begin
				hist_q[j] <= '0;
			end
			pos_q <= '0;
		end else if (acc) begin
			if (samples.final_sample) begin
				for (int j = 0; j < TAPS - 1; j++) begin
					hist_q[j] <= '0;
				end
				pos_q <= '0;
			end else begin
				for (int j = 0; j < TAPS - 1; j++) begin
					hist_q[j] <= win_n[j];
				end
				pos_q <= (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1 && emit_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s1  <= win_n;
			fin_s1  <= samples.final_sample;
			emit_s1 <= samples.final_sample || pos_q >= POS_W'(HALF);
			usef_s1 <= pos_q > POS_W'(2 * HALF);
			if (samples.final_sample && pos_q < POS_W'(HALF)) begin
				age_s1 <= pos_q[AW-1:0];
			end else begin
				age_s1 <= AW'(HALF);
			end

			for (int j = 0; j < TAPS; j++) begin
				prod_s2[j] <= taps_q[j] * win_s1[j];
			end
			for (int j = 0; j <= HALF; j++) begin
				win_s2[j] <= win_s1[j];
			end
			fin_s2  <= fin_s1;
			usef_s2 <= usef_s1;
			age_s2  <= age_s1;

			filt_s3 <= sat_c;
			win_s3  <= win_s2;
			fin_s3  <= fin_s2;
			usef_s3 <= usef_s2;
			age_s3  <= age_s2;
		end
	end

	// Round half up, floor shift, then clamp to the sample range.
	always_comb begin
		sum_c = '0;
		for (int j = 0; j < TAPS; j++) begin
			sum_c = sum_c + SW'(prod_s2[j]);
		end
		rnd_c = sum_c + SW'(ROUND_BIAS);
		quo_c = QW'(rnd_c >>> FRAC_W);
		if (quo_c > QW'(SAT_HI)) begin
			sat_c = SAMPLE_MAX;
		end else if (quo_c < QW'(SAT_LO)) begin
			sat_c = SAMPLE_MIN;
		end else begin
			sat_c = quo_c[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			busy_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			filt_q <= filt_s3;
			win_q  <= win_s3;
			fin_q  <= fin_s3;
			usef_q <= usef_s3;
			age_q  <= age_s3;
		end else if (busy_q && results.ready) begin
			age_q <= age_q - 1'b1;
		end
	end

	assign pass_c = !(age_q == AW'(HALF) && usef_q);

	assign results.valid          = busy_q;
	assign results.value          = pass_c ? win_q[age_q] : filt_q;
	assign results.passed_through = pass_c;
	assign results.run_end        = fin_q && age_q == '0;

`include "fir_same_edge_passthrough_assert.svh"

	`FSEP_ASSERT_NOW(a_filt_not_last, results.valid && !results.passed_through,
		!results.run_end, "filtered word marked as end of record")
	`FSEP_ASSERT_NEXT(a_burst_continues,
		results.valid && results.ready && fin_q && !results.run_end,
		results.valid, "final burst broken before its last word")
	`FSEP_ASSERT_NEXT(a_pos_cleared, samples.valid && samples.ready && samples.final_sample,
		pos_q == '0 && hist_q[0] == '0, "record state not cleared after final sample")
	`FSEP_ASSERT_NOW(a_no_take_mid_burst, busy_q && !emit_done, !samples.ready,
		"sample taken while a burst is still pending")

endmodule

`default_nettype wire
